>>> sv/hcbd_pkg.sv
// shared types, constants and byte classifiers for the chunked body decoder
`timescale 1ns / 1ps
`default_nettype none
package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 32;

  // final status codes
  localparam logic [2:0] ST_ZERO_CHUNK = 3'd0;
  localparam logic [2:0] ST_NO_ZERO    = 3'd1;
  localparam logic [2:0] ST_NO_DIGITS  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_res;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic emit;
    out_t word;
  } res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_dec(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage
`default_nettype wire

>>> sv/hcbd_parse.sv
// chunk framing state machine: size line parse, payload count, trailing crlf
`timescale 1ns / 1ps
`default_nettype none
module hcbd_parse #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire hcbd_pkg::in_t item,
  output hcbd_pkg::res_t    res
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_HEX, PH_TAIL, PH_DATA, PH_AFTER, PH_DONE, PH_ERROR
  } phase_t;

  phase_t               ph_r, ph_nxt;
  logic [SIZE_BITS-1:0] bl_r, bl_nxt;
  logic                 ds_r, ds_nxt;
  logic                 lz_r, lz_nxt;
  logic                 pc_r, pc_nxt;
  logic [2:0]           fc_r, fc_nxt;

  logic [7:0] b;
  logic [4:0] hx;
  logic       data;
  logic       go_after, a_pc;
  logic       to_lead, l_pc;
  logic       fin;
  logic [2:0] st;

  assign b  = item.in_byte;
  assign hx = hcbd_pkg::hex_dec(b);

  always_comb begin
    ph_nxt   = ph_r;
    bl_nxt   = bl_r;
    ds_nxt   = ds_r;
    lz_nxt   = lz_r;
    pc_nxt   = pc_r;
    fc_nxt   = fc_r;
    data     = 1'b0;
    go_after = 1'b0;
    a_pc     = 1'b0;
    to_lead  = 1'b0;
    l_pc     = pc_r;
    fin      = 1'b0;

    if (ph_r == PH_LEAD && !pc_r) begin
      ds_nxt = 1'b0;
      lz_nxt = 1'b0;
    end

    unique case (ph_r)
      PH_LEAD: begin
        to_lead = 1'b1;
      end
      PH_HEX: begin
        lz_nxt = 1'b0;
        if (lz_r && (b == hcbd_pkg::CH_X_LO || b == hcbd_pkg::CH_X_UP)) begin
          // 0x prefix
        end else if (hx[4]) begin
          if (bl_r[SIZE_BITS-1 -: 4] != 4'd0) begin
            ph_nxt = PH_ERROR;
            fc_nxt = hcbd_pkg::ST_OVERFLOW;
            pc_nxt = 1'b0;
          end else begin
            bl_nxt = {bl_r[SIZE_BITS-5:0], hx[3:0]};
          end
        end else begin
          ph_nxt = PH_TAIL;
          pc_nxt = (b == hcbd_pkg::CH_CR);
        end
      end
      PH_TAIL: begin
        if (pc_r && b == hcbd_pkg::CH_LF) begin
          fin = 1'b1;
        end else begin
          pc_nxt = (b == hcbd_pkg::CH_CR);
        end
      end
      PH_DATA: begin
        if (bl_r == '0) begin
          go_after = 1'b1;
        end else begin
          data   = 1'b1;
          bl_nxt = bl_r - 1'b1;
          if (bl_r == SIZE_BITS'(1)) begin
            ph_nxt = PH_AFTER;
            pc_nxt = 1'b0;
          end
        end
      end
      PH_AFTER: begin
        go_after = 1'b1;
        a_pc     = pc_r;
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    // optional crlf after payload; anything else starts the next size line
    if (go_after) begin
      if (!a_pc && b == hcbd_pkg::CH_CR) begin
        ph_nxt = PH_AFTER;
        pc_nxt = 1'b1;
      end else begin
        ph_nxt = PH_LEAD;
        pc_nxt = 1'b0;
        ds_nxt = 1'b0;
        lz_nxt = 1'b0;
        if (!(a_pc && b == hcbd_pkg::CH_LF)) begin
          to_lead = 1'b1;
          l_pc    = 1'b0;
        end
      end
    end

    if (to_lead) begin
      if (l_pc && b == hcbd_pkg::CH_LF) begin
        fin = 1'b1;
      end else begin
        pc_nxt = 1'b0;
        if (b == hcbd_pkg::CH_CR) begin
          pc_nxt = 1'b1;
        end else if (hcbd_pkg::is_space(b)) begin
        end else if (hx[4]) begin
          ph_nxt = PH_HEX;
          ds_nxt = 1'b1;
          bl_nxt = SIZE_BITS'(hx[3:0]);
          lz_nxt = (hx[3:0] == 4'd0);
        end else begin
          ph_nxt = PH_ERROR;
          fc_nxt = hcbd_pkg::ST_NO_DIGITS;
        end
      end
    end

    if (fin) begin
      pc_nxt = 1'b0;
      if (!ds_nxt) begin
        ph_nxt = PH_ERROR;
        fc_nxt = hcbd_pkg::ST_NO_DIGITS;
      end else if (bl_nxt == '0) begin
        ph_nxt = PH_DONE;
        fc_nxt = hcbd_pkg::ST_ZERO_CHUNK;
      end else begin
        ph_nxt = PH_DATA;
      end
    end

    st = (ph_nxt == PH_DATA && bl_nxt != '0) ? hcbd_pkg::ST_TRUNCATED : fc_nxt;

    res.emit          = data || item.last;
    res.word.out_byte = data ? b : 8'd0;
    res.word.is_data  = data;
    res.word.end_res  = item.last;
    res.word.status   = item.last ? st : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      ph_r <= PH_LEAD;
      bl_r <= '0;
      ds_r <= 1'b0;
      lz_r <= 1'b0;
      pc_r <= 1'b0;
      fc_r <= hcbd_pkg::ST_NO_ZERO;
    end else if (step) begin
      ph_r <= ph_nxt;
      bl_r <= bl_nxt;
      ds_r <= ds_nxt;
      lz_r <= lz_nxt;
      pc_r <= pc_nxt;
      fc_r <= fc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/http_chunked_body_decoder.sv
// top level: input register, framing parser and output register
//
//  channel  dir  handshake             payload
//  in_      in   in_valid / in_ready   in_data   (hcbd_pkg::in_t)
//  out_     out  out_valid / out_ready out_data  (hcbd_pkg::out_t)
//
// one word per cycle while the output is not stalled; parser state is registered
// a result is registered into the output register as its word leaves the input one
// words that carry neither payload nor the last flag give no result
// a full output register with out_ready low holds a waiting word that gives a result
// rst_n is synchronous; the parser restarts on reset and after each last word
`timescale 1ns / 1ps
`default_nettype none
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hcbd_pkg::in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hcbd_pkg::out_t out_data
);

  logic           s1_valid_r, s1_valid_nxt;
  hcbd_pkg::in_t  s1_word_r;
  logic           out_valid_r;
  hcbd_pkg::out_t out_word_r;
  hcbd_pkg::res_t res;
  logic           out_free;
  logic           s1_adv;
  logic           in_take;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!res.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  hcbd_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk  (clk),
    .rst_n(rst_n),
    .step (s1_adv),
    .item (s1_word_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv && res.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_data;
    end
    if (s1_adv && res.emit) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
`default_nettype wire

>>> sv/hcbd_checker.sv
// port-level checks on the decoder's result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module hcbd_checker (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire hcbd_pkg::out_t out_data
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // a result carries payload or closes the body
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.is_data || out_data.end_res)
    else $error("result with neither payload nor end");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data |-> out_data.out_byte == 8'd0)
    else $error("nonzero byte on a non-payload result");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.end_res |-> out_data.status == 3'd0)
    else $error("status set before the last word");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_res |-> out_data.status <= hcbd_pkg::ST_TRUNCATED)
    else $error("final status out of range");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
